@@ src/wrhf_pkg.sv @@
package wrhf_pkg;

  typedef enum logic [1:0] {
    ACT_SPAWN  = 2'd0,
    ACT_STEP   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam int unsigned CFG_ENABLE  = 0;
  localparam int unsigned CFG_TEXLOG  = 1;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 3;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned STRENGTH_W = 10;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned TEXEL_W    = 14;

  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [STRENGTH_W-1:0] strength;
  } req_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic [TEXEL_W-1:0]         texel_index;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SP_RD,
    ST_SP_WAIT,
    ST_SP_WR,
    ST_STEP_RD,
    ST_STEP_WAIT,
    ST_STEP_WR,
    ST_LK_RD,
    ST_LK_WAIT,
    ST_LK_CALC,
    ST_OUT
  } state_t;

  // Datapath commands.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_WR,
    OP_LATCH,
    OP_SP_RD,
    OP_SP_WR,
    OP_ST_RD,
    OP_ST_CAP,
    OP_ST_WR,
    OP_SWAP,
    OP_LK_RD,
    OP_LK_CALC,
    OP_ZERO
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic last;
  } stat_t;

endpackage

@@ src/wrhf_if.sv @@
interface wrhf_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/wrhf_ram.sv @@
module wrhf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/wrhf_ctrl.sv @@
module wrhf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic               enable,
  output logic               out_valid,
  input  logic               out_ready,
  output wrhf_pkg::ctrl_t    ctrl,
  input  wrhf_pkg::stat_t    stat
);
  import wrhf_pkg::*;

  state_t state_r, state_nxt;
  logic [2:0] sub_r, sub_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      sub_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sub_r   <= sub_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sub_nxt   = sub_r;
    unique case (state_r)
      ST_CLEAR:     if (stat.last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        sub_nxt = '0;
        if (in_valid) begin
          priority if (action == ACT_SPAWN && enable) state_nxt = ST_SP_RD;
          else if (action == ACT_STEP && enable)      state_nxt = ST_STEP_RD;
          else if (action == ACT_LOOKUP)              state_nxt = ST_LK_RD;
          else                                        state_nxt = ST_OUT;
        end
      end
      ST_SP_RD:     state_nxt = ST_SP_WAIT;
      ST_SP_WAIT:   state_nxt = ST_SP_WR;
      ST_SP_WR: begin
        sub_nxt = sub_r + 3'd1;
        state_nxt = (sub_r == 3'd4) ? ST_OUT : ST_SP_RD;
      end
      ST_STEP_RD: begin
        sub_nxt = sub_r + 3'd1;
        if (sub_r == 3'd4) state_nxt = ST_STEP_WAIT;
      end
      ST_STEP_WAIT: state_nxt = ST_STEP_WR;
      ST_STEP_WR: begin
        sub_nxt = '0;
        state_nxt = stat.last ? ST_OUT : ST_STEP_RD;
      end
      ST_LK_RD:     state_nxt = ST_LK_WAIT;
      ST_LK_WAIT:   state_nxt = ST_LK_CALC;
      ST_LK_CALC:   state_nxt = ST_OUT;
      ST_OUT:       if (out_ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.op   = OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR:     ctrl.op = OP_CLR_WR;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctrl.op = OP_LATCH;
      end
      ST_SP_RD:     ctrl.op = OP_SP_RD;
      ST_SP_WAIT:   ctrl.op = OP_SP_RD;
      ST_SP_WR:     ctrl.op = OP_SP_WR;
      ST_STEP_RD:   ctrl.op = (sub_r == 3'd0) ? OP_ST_RD : OP_ST_CAP;
      ST_STEP_WAIT: ctrl.op = OP_ST_CAP;
      ST_STEP_WR:   ctrl.op = stat.last ? OP_SWAP : OP_ST_WR;
      ST_LK_RD:     ctrl.op = OP_LK_RD;
      ST_LK_WAIT:   ctrl.op = OP_LK_RD;
      ST_LK_CALC:   ctrl.op = OP_LK_CALC;
      ST_OUT:       out_valid = 1'b1;
      default:      ctrl.op = OP_NONE;
    endcase
  end
endmodule

@@ src/wrhf_dp.sv @@
module wrhf_dp #(
  parameter int GRID_WIDTH = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wrhf_pkg::ctrl_t      ctrl,
  output wrhf_pkg::stat_t      stat,
  input  wrhf_pkg::req_t       req,
  input  logic [2:0]           tex_size_log2,
  output wrhf_pkg::rsp_t       rsp
);
  import wrhf_pkg::*;

  localparam int GL    = $clog2(GRID_WIDTH);
  localparam int CW    = 2 * GL;
  localparam int AW    = CW + 1;
  localparam int CELLS = GRID_WIDTH * GRID_WIDTH;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [15:0]     wdata, rdata;

  wrhf_ram #(.WIDTH(16), .DEPTH(2 * CELLS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic            half_r;
  logic [AW-1:0]   clr_r;
  logic [CW-1:0]   cell_r;
  logic [2:0]      tap_r;
  logic [2:0]      cap_r;
  logic [2:0]      sp_r;
  logic signed [17:0] sum_r;
  logic [15:0]     old_r;
  req_t            req_r;
  rsp_t            rsp_r;
  logic [GL-1:0]   x_r, y_r;
  logic [2:0]      wb_r;

  logic [GL-1:0]   cx, cy;
  logic [GL-1:0]   sx, sy;
  logic [15:0]     sp_val;
  logic [CW-1:0]   tap_cell;
  logic signed [16:0] half_sum;
  logic [15:0]     t16, v16;
  logic [2:0]      wb;
  logic [GL-1:0]   m, lx, ly;
  logic signed [15:0] h, d;

  assign cx = GL'(req_r.pos_x);
  assign cy = GL'(req_r.pos_y);

  always_comb begin
    sx = cx;
    sy = cy;
    unique case (sp_r)
      3'd1:    sx = cx + GL'(1);
      3'd2:    sx = cx - GL'(1);
      3'd3:    sy = cy + GL'(1);
      3'd4:    sy = cy - GL'(1);
      default: ;
    endcase
    sp_val = (sp_r == 3'd0) ? 16'(req_r.strength) : 16'(req_r.strength >> 2);
  end

  always_comb begin
    unique case (tap_r)
      3'd0:    tap_cell = cell_r - CW'(GRID_WIDTH);
      3'd1:    tap_cell = cell_r - CW'(1);
      3'd2:    tap_cell = cell_r + CW'(1);
      3'd3:    tap_cell = cell_r + CW'(GRID_WIDTH);
      default: tap_cell = cell_r;
    endcase
  end

  always_comb begin
    half_sum = 17'(sum_r >>> 1);
    t16 = 16'(half_sum) - old_r;
    v16 = t16 - 16'($signed(t16) >>> 6);
  end

  always_comb begin
    wb = (32'(tex_size_log2) > GL) ? 3'(GL) : tex_size_log2;
    m  = GL'((1 << wb) - 1);
    lx = GL'(req_r.pos_x) & m;
    ly = GL'(req_r.pos_y) & m;
    h  = $signed(rdata);
    d  = h >>> 4;
  end

  always_comb begin
    we    = 1'b0;
    waddr = {half_r, cell_r};
    wdata = '0;
    raddr = {half_r, tap_cell};
    unique case (ctrl.op)
      OP_CLR_WR: begin
        we = 1'b1; waddr = clr_r;
      end
      OP_SP_RD:  raddr = {half_r, sy, sx};
      OP_SP_WR: begin
        we = 1'b1; waddr = {half_r, sy, sx}; wdata = rdata + sp_val;
      end
      OP_ST_RD, OP_ST_CAP: begin
        raddr = (tap_r == 3'd4) ? {~half_r, cell_r} : {half_r, tap_cell};
      end
      OP_ST_WR, OP_SWAP: begin
        we = 1'b1; waddr = {~half_r, cell_r}; wdata = v16;
      end
      OP_LK_RD:  raddr = {half_r, CW'((ly << (GL - wb)) * GRID_WIDTH + (lx << (GL - wb)))};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
      clr_r  <= '0;
    end else begin
      if (ctrl.op == OP_CLR_WR) clr_r <= clr_r + AW'(1);
      if (ctrl.op == OP_SWAP) half_r <= ~half_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LATCH: begin
        req_r  <= req;
        cell_r <= '0;
        tap_r  <= '0;
        cap_r  <= '0;
        sp_r   <= '0;
        sum_r  <= '0;
        rsp_r  <= '0;
      end
      OP_SP_WR: sp_r <= sp_r + 3'd1;
      OP_ST_RD, OP_ST_CAP: begin
        tap_r <= (tap_r == 3'd4) ? tap_r : tap_r + 3'd1;
        if (ctrl.op == OP_ST_CAP) begin
          cap_r <= cap_r + 3'd1;
          if (cap_r == 3'd4) old_r <= rdata;
          else sum_r <= sum_r + 18'($signed(rdata));
        end
      end
      OP_ST_WR: begin
        cell_r <= cell_r + CW'(1);
        tap_r  <= '0;
        cap_r  <= '0;
        sum_r  <= '0;
      end
      OP_LK_RD: begin
        x_r  <= lx;
        y_r  <= ly;
        wb_r <= wb;
      end
      OP_LK_CALC: begin
        rsp_r.height      <= h;
        rsp_r.texel_index <= TEXEL_W'((32'(GL'(y_r - GL'(d)) & m) << wb_r)
                                      + 32'(GL'(x_r + GL'(d)) & m));
      end
      default: ;
    endcase
  end

  assign stat.last = (ctrl.op == OP_CLR_WR) ? (clr_r == AW'(2 * CELLS - 1))
                                            : (cell_r == CW'(CELLS - 1));
  assign rsp = rsp_r;
endmodule

@@ src/water_ripple_height_field.sv @@
// Ripple height field over two 128x128 grids in one 32768-entry RAM. After reset
// a clearing pass zeroes the RAM; no item is taken meanwhile. Spawn does five
// read-modify-writes, lookup a single read, and a step sweeps every cell,
// fetching four neighbours and the old value per cell through the single-read
// RAM port. A disabled or unused item goes straight to its result.
// One item is in flight at a time; the result holds until taken.
module water_ripple_height_field #(
  parameter int GRID_WIDTH = 128
) (
  input  logic clk,
  input  logic rst_n,
  wrhf_if.sink   in_ch,
  wrhf_if.source out_ch,
  input  logic                            cfg_we,
  input  logic [wrhf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrhf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wrhf_pkg::*;

  logic       enable_r;
  logic [2:0] tex_log2_r;
  ctrl_t      ctrl;
  stat_t      stat;
  req_t       req;
  rsp_t       rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b1;
      tex_log2_r <= 3'd7;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_W'(CFG_ENABLE)) enable_r <= cfg_data[0];
      if (cfg_index == CFG_IDX_W'(CFG_TEXLOG)) tex_log2_r <= cfg_data;
    end
  end

  assign req = in_ch.data;

  wrhf_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .action   (req.action),
    .enable   (enable_r),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .ctrl, .stat
  );

  wrhf_dp #(.GRID_WIDTH(GRID_WIDTH)) u_dp (
    .clk, .rst_n, .ctrl, .stat, .req,
    .tex_size_log2(tex_log2_r),
    .rsp
  );

  assign out_ch.data = rsp;
endmodule
